/* hw/rtl/kmd_pkg.sv */
// shared types, constants and helpers for the key matrix decoder
package kmd_pkg;

  localparam int ROWS          = 4;
  localparam int COLS          = 12;
  localparam int KEY_W         = 48;
  localparam int MAP_CELLS     = (ROWS * COLS < KEY_W) ? ROWS * COLS : KEY_W;
  localparam int MAP_DEPTH     = 4 * ROWS * COLS;
  localparam int CELL_W        = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int ADDR_W        = 8;
  localparam int MEM_ADDR_W    = $clog2(MAP_DEPTH);
  localparam int CHAR_W        = 8;
  localparam int LEVEL_W       = 10;
  localparam int TIME_W        = 16;
  localparam int FLAGS_W       = 3;
  localparam int SCAN_W        = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam int FLAG_SHIFT    = 0;
  localparam int FLAG_ALT      = 1;
  localparam int FLAG_CTRL     = 2;

  localparam logic [SCAN_W-1:0] RELEASE_SCANS = SCAN_W'(6);

  localparam logic REQ_SCAN      = 1'b0;
  localparam logic REQ_MAP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MOD_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_HOLD     = CFG_IDX_W'(1);

  localparam logic [LEVEL_W-1:0] MOD_THRESHOLD_RESET = LEVEL_W'(512);
  localparam logic [TIME_W-1:0]  FLAG_HOLD_RESET     = TIME_W'(1000);

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  key_bits;
    logic [LEVEL_W-1:0] alt_level;
    logic [LEVEL_W-1:0] ctrl_level;
    logic [LEVEL_W-1:0] shift_level;
    logic [TIME_W-1:0] time_ms;
    logic [ADDR_W-1:0] map_index;
    logic [CHAR_W-1:0] map_value;
  } in_item_t;

  typedef struct packed {
    logic               char_valid;
    logic [CHAR_W-1:0]  char_code;
    logic [FLAGS_W-1:0] modifier_flags;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] mod_threshold;
    logic [TIME_W-1:0]  flag_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic                  we;
    logic [MEM_ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0]     wdata;
    logic                  re;
    logic [MEM_ADDR_W-1:0] raddr;
  } km_req_t;

  // highest pressed cell wins
  function automatic logic [CELL_W-1:0] pick_cell(input logic [KEY_W-1:0] bits);
    logic [CELL_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < MAP_CELLS; i++) begin
      if (bits[i]) begin
        pos = CELL_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* hw/rtl/key_matrix_decoder.sv */
// top level of the key matrix decoder with configuration registers
//
// Takes one transaction per cycle, either a scan frame or a keymap write, and
// gives exactly one result per transaction: the key pick, modifier update and
// keymap read are registered in the first stage, the result in the output
// register. The keymap read port is the only memory access in the
// path, so sustained throughput is one transaction per cycle while out_stall
// stays low. The 192 x 8 keymap has no reset and must be loaded before scan
// frames reach the confirm phase. Register 0 is the modifier threshold
// (10 bits), register 1 the sticky flag hold time in milliseconds (16 bits).
module key_matrix_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  kmd_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output kmd_pkg::out_item_t               out_data
);
  import kmd_pkg::*;

  cfg_t              cfg;
  km_req_t           km_req;
  logic [CHAR_W-1:0] km_rdata;
  logic              res_valid;
  logic              res_stall;
  out_item_t         res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mod_threshold <= MOD_THRESHOLD_RESET;
      cfg.flag_hold_ms  <= FLAG_HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOD_THRESHOLD: cfg.mod_threshold <= cfg_data[LEVEL_W-1:0];
        REG_FLAG_HOLD:     cfg.flag_hold_ms  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  kmd_keymap u_keymap (
    .clk   (clk),
    .req   (km_req),
    .rdata (km_rdata)
  );

  kmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .km_req    (km_req),
    .km_rdata  (km_rdata),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  kmd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/kmd_keymap.sv */
// keymap storage, one write port and one registered read port
module kmd_keymap (
  input  logic                      clk,
  input  kmd_pkg::km_req_t          req,
  output logic [kmd_pkg::CHAR_W-1:0] rdata
);
  import kmd_pkg::*;

  logic [CHAR_W-1:0] mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* hw/rtl/kmd_ctrl.sv */
// scan phase tracking, sticky modifiers, keymap addressing and result forming
module kmd_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  kmd_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  kmd_pkg::in_item_t           in_data,
  output kmd_pkg::km_req_t            km_req,
  input  logic [kmd_pkg::CHAR_W-1:0]  km_rdata,
  output logic                        res_valid,
  input  logic                        res_stall,
  output kmd_pkg::out_item_t          res_data
);
  import kmd_pkg::*;

  logic               phase;
  logic [SCAN_W-1:0]  scan_count;
  logic [FLAGS_W-1:0] flags;
  logic [TIME_W-1:0]  stamp;

  logic               phase_next;
  logic [SCAN_W-1:0]  scan_count_next;
  logic [FLAGS_W-1:0] flags_next;
  logic [TIME_W-1:0]  stamp_next;

  logic               s1_valid;
  logic               s1_cand;
  logic [FLAGS_W-1:0] s1_flags;

  logic               accept;
  logic               emit;
  logic               cur_phase;
  logic [SCAN_W-1:0]  cur_scan;
  logic               pressed;
  logic [CELL_W-1:0]  key_pos;
  logic [FLAGS_W-1:0] mod_hits;
  logic [FLAGS_W-1:0] flags_mod;
  logic [TIME_W-1:0]  stamp_mod;
  logic [TIME_W-1:0]  elapsed;
  logic               expired;
  logic [FLAGS_W-1:0] flags_left;
  logic [1:0]         layer;
  logic [SCAN_W-1:0]  scan_inc;
  logic               cand;
  logic [FLAGS_W-1:0] shown;

  assign in_stall = s1_valid && res_stall;
  assign accept   = in_valid && !in_stall;

  // the pending transaction resolves once its keymap code is read and nonzero
  assign emit      = s1_valid && s1_cand && (km_rdata != '0);
  assign cur_phase = emit ? 1'b0 : phase;
  assign cur_scan  = emit ? '0 : scan_count;

  assign pressed = |in_data.key_bits[MAP_CELLS-1:0];
  assign key_pos = pick_cell(in_data.key_bits);

  assign mod_hits[FLAG_SHIFT] = in_data.shift_level < cfg.mod_threshold;
  assign mod_hits[FLAG_ALT]   = in_data.alt_level < cfg.mod_threshold;
  assign mod_hits[FLAG_CTRL]  = in_data.ctrl_level < cfg.mod_threshold;

  assign flags_mod  = flags | mod_hits;
  assign stamp_mod  = (|mod_hits) ? in_data.time_ms : stamp;
  assign elapsed    = in_data.time_ms - stamp_mod;
  assign expired    = elapsed > cfg.flag_hold_ms;
  assign flags_left = expired ? '0 : flags_mod;
  assign layer      = {flags_left[FLAG_ALT], flags_left[FLAG_SHIFT]};
  assign scan_inc   = cur_scan + SCAN_W'(1);

  always_comb begin
    phase_next      = cur_phase;
    scan_count_next = cur_scan;
    flags_next      = flags;
    stamp_next      = stamp;
    cand            = 1'b0;
    shown           = flags;
    km_req.we       = 1'b0;
    km_req.waddr    = in_data.map_index[MEM_ADDR_W-1:0];
    km_req.wdata    = in_data.map_value;
    km_req.re       = 1'b0;
    km_req.raddr    = MEM_ADDR_W'(MEM_ADDR_W'(layer) * MEM_ADDR_W'(MAP_CELLS))
                      + MEM_ADDR_W'(key_pos);
    if (accept) begin
      if (in_data.req_type == REQ_MAP_WRITE) begin
        km_req.we = in_data.map_index < ADDR_W'(MAP_DEPTH);
      end else if (!cur_phase) begin
        scan_count_next = pressed ? SCAN_W'(1) : scan_inc;
        if (scan_count_next >= RELEASE_SCANS) begin
          phase_next      = 1'b1;
          scan_count_next = '0;
        end
      end else begin
        shown           = flags_mod;
        flags_next      = flags_left;
        stamp_next      = expired ? in_data.time_ms : stamp_mod;
        scan_count_next = SCAN_W'(1);
        if (pressed) begin
          km_req.re  = 1'b1;
          flags_next = '0;
          stamp_next = in_data.time_ms;
          cand       = cur_scan == SCAN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 1'b0;
      scan_count <= '0;
      flags      <= '0;
      stamp      <= '0;
      s1_valid   <= 1'b0;
    end else begin
      phase      <= phase_next;
      scan_count <= scan_count_next;
      flags      <= flags_next;
      stamp      <= stamp_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (!res_stall) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cand  <= cand;
      s1_flags <= shown;
    end
  end

  assign res_valid               = s1_valid;
  assign res_data.char_valid     = emit;
  assign res_data.char_code      = emit ? km_rdata : '0;
  assign res_data.modifier_flags = s1_flags;

endmodule

/* hw/rtl/kmd_out_reg.sv */
// output register between the result stage and the downstream consumer
module kmd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_stall,
  input  kmd_pkg::out_item_t res_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kmd_pkg::out_item_t out_data
);
  import kmd_pkg::*;

  logic load;

  assign res_stall = out_valid && out_stall;
  assign load      = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res_data;
    end
  end

endmodule
